// ===== design/assert_macros.svh =====
// Assertion macros used by the checker in dcpe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dcpe_pkg.sv =====
package dcpe_pkg;

  typedef struct packed {
    logic signed [15:0] velocity_mm_s;
    logic signed [15:0] radius_mm;
  } cmd_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } pkt_t;

  localparam int unsigned PROD_W    = 26;
  localparam int unsigned HALF_WB_W = 10;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [HALF_WB_W-1:0] HALF_WB_RESET = 10'd115;
  localparam logic                 REG_HALF_WB   = 1'b0;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [15:0]       vabs;
    logic [15:0]       dvsr;
    logic              neg;
    logic [15:0]       radius;
  } job_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] radius;
  } frame_t;

  localparam logic [7:0] HDR0     = 8'hAA;
  localparam logic [7:0] HDR1     = 8'h55;
  localparam logic [7:0] LEN_BYTE = 8'h06;
  localparam logic [7:0] SUB0     = 8'h01;
  localparam logic [7:0] SUB1     = 8'h04;

  localparam logic [3:0] POS_HDR0 = 4'd0;
  localparam logic [3:0] POS_HDR1 = 4'd1;
  localparam logic [3:0] POS_LEN  = 4'd2;
  localparam logic [3:0] POS_SUB0 = 4'd3;
  localparam logic [3:0] POS_SUB1 = 4'd4;
  localparam logic [3:0] POS_SPL  = 4'd5;
  localparam logic [3:0] POS_SPH  = 4'd6;
  localparam logic [3:0] POS_RDL  = 4'd7;
  localparam logic [3:0] POS_RDH  = 4'd8;
  localparam logic [3:0] POS_CK   = 4'd9;

endpackage

// ===== design/dcpe_front.sv =====
module dcpe_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [dcpe_pkg::HALF_WB_W-1:0]      half_wb,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  dcpe_pkg::cmd_t                      cmd,
  output logic                                job_valid,
  input  logic                                job_ready,
  output dcpe_pkg::job_t                      job
);

  logic        vneg;
  logic        rzero;
  logic [15:0] vabs;
  logic [15:0] rabs;

  assign vneg  = cmd.velocity_mm_s[15];
  assign rzero = (cmd.radius_mm == 16'sd0);
  assign vabs  = vneg ? 16'(-cmd.velocity_mm_s) : 16'(cmd.velocity_mm_s);
  assign rabs  = cmd.radius_mm[15] ? 16'(-cmd.radius_mm) : 16'(cmd.radius_mm);

  assign cmd_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (cmd_ready) begin
      job_valid <= cmd_valid;
    end
  end

  // A straight command divides zero by one, so the speed stays the velocity.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      job.prod   <= rzero ? '0 :
                    dcpe_pkg::PROD_W'(vabs) * dcpe_pkg::PROD_W'(half_wb);
      job.vabs   <= vabs;
      job.dvsr   <= rzero ? 16'd1 : rabs;
      job.neg    <= vneg;
      job.radius <= cmd.radius_mm;
    end
  end

endmodule

// ===== design/dcpe_div.sv =====
module dcpe_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  dcpe_pkg::job_t    job,
  output logic              frm_valid,
  input  logic              frm_ready,
  output dcpe_pkg::frame_t  frm
);

  localparam logic [1:0]  ST_IDLE  = 2'd0;
  localparam logic [1:0]  ST_RUN   = 2'd1;
  localparam logic [1:0]  ST_DONE  = 2'd2;
  localparam logic [2:0]  STEP_LAST = 3'd7;
  localparam logic [16:0] POS_LIMIT = 17'd32767;
  localparam logic [16:0] NEG_LIMIT = 17'd32768;
  localparam logic [15:0] SAT_POS   = 16'h7FFF;
  localparam logic [15:0] SAT_NEG   = 16'h8000;

  logic [1:0]  state;
  logic [2:0]  cnt;
  logic [15:0] rem;
  logic [15:0] shq;
  logic [15:0] dvsr;
  logic [15:0] vabs;
  logic        neg;
  logic        ovf;
  logic [15:0] radius;

  logic        load;
  logic [16:0] t1;
  logic [16:0] t2;
  logic [16:0] d1;
  logic [16:0] d2;
  logic        ge1;
  logic        ge2;
  logic [15:0] r1;
  logic [15:0] rem_next;
  logic [16:0] sum;
  logic [16:0] nsum;

  assign job_ready = (state == ST_IDLE) || ((state == ST_DONE) && frm_ready);
  assign load      = job_valid && job_ready;
  assign frm_valid = (state == ST_DONE);

  // Two restoring division steps per cycle.
  always_comb begin
    t1       = {rem, shq[15]};
    d1       = t1 - {1'b0, dvsr};
    ge1      = (t1 >= {1'b0, dvsr});
    r1       = ge1 ? d1[15:0] : t1[15:0];
    t2       = {r1, shq[14]};
    d2       = t2 - {1'b0, dvsr};
    ge2      = (t2 >= {1'b0, dvsr});
    rem_next = ge2 ? d2[15:0] : t2[15:0];
  end

  always_comb begin
    sum  = {1'b0, vabs} + {1'b0, shq};
    nsum = -sum;
    frm.radius = radius;
    if (neg) begin
      frm.speed = (ovf || (sum > NEG_LIMIT)) ? SAT_NEG : nsum[15:0];
    end else begin
      frm.speed = (ovf || (sum > POS_LIMIT)) ? SAT_POS : sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (load) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 3'd1;
          if (cnt == STEP_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_RUN;
            cnt   <= '0;
          end else if (frm_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ovf    <= ({6'b0, job.prod} >= {job.dvsr, 16'h0000});
      rem    <= 16'(job.prod[dcpe_pkg::PROD_W-1:16]);
      shq    <= job.prod[15:0];
      dvsr   <= job.dvsr;
      vabs   <= job.vabs;
      neg    <= job.neg;
      radius <= job.radius;
    end else if (state == ST_RUN) begin
      rem <= rem_next;
      shq <= {shq[13:0], ge1, ge2};
    end
  end

endmodule

// ===== design/dcpe_queue.sv =====
module dcpe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  dcpe_pkg::frame_t  wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output dcpe_pkg::frame_t  rd_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dcpe_pkg::frame_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt != CNT_W'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== design/dcpe_back.sv =====
module dcpe_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              frm_valid,
  output logic              frm_ready,
  input  dcpe_pkg::frame_t  frm,
  output logic              pkt_valid,
  input  logic              pkt_ready,
  output dcpe_pkg::pkt_t    pkt
);

  logic        busy;
  logic [3:0]  pos;
  logic [15:0] speed;
  logic [15:0] radius;
  logic        adv;
  logic        last_pos;
  logic [7:0]  ck;
  logic [7:0]  byte_sel;

  assign adv       = busy && (!pkt_valid || pkt_ready);
  assign last_pos  = (pos == dcpe_pkg::POS_CK);
  assign frm_ready = !busy || (adv && last_pos);

  assign ck = dcpe_pkg::LEN_BYTE ^ dcpe_pkg::SUB0 ^ dcpe_pkg::SUB1 ^
              speed[7:0] ^ speed[15:8] ^ radius[7:0] ^ radius[15:8];

  always_comb begin
    case (pos)
      dcpe_pkg::POS_HDR0: byte_sel = dcpe_pkg::HDR0;
      dcpe_pkg::POS_HDR1: byte_sel = dcpe_pkg::HDR1;
      dcpe_pkg::POS_LEN:  byte_sel = dcpe_pkg::LEN_BYTE;
      dcpe_pkg::POS_SUB0: byte_sel = dcpe_pkg::SUB0;
      dcpe_pkg::POS_SUB1: byte_sel = dcpe_pkg::SUB1;
      dcpe_pkg::POS_SPL:  byte_sel = speed[7:0];
      dcpe_pkg::POS_SPH:  byte_sel = speed[15:8];
      dcpe_pkg::POS_RDL:  byte_sel = radius[7:0];
      dcpe_pkg::POS_RDH:  byte_sel = radius[15:8];
      dcpe_pkg::POS_CK:   byte_sel = ck;
      default:            byte_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= dcpe_pkg::POS_HDR0;
      pkt_valid <= 1'b0;
    end else begin
      if (frm_valid && frm_ready) begin
        busy <= 1'b1;
        pos  <= dcpe_pkg::POS_HDR0;
      end else if (adv) begin
        pos <= pos + 4'd1;
        if (last_pos) begin
          busy <= 1'b0;
        end
      end
      if (adv) begin
        pkt_valid <= 1'b1;
      end else if (pkt_ready) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && frm_ready) begin
      speed  <= frm.speed;
      radius <= frm.radius;
    end
    if (adv) begin
      pkt.packet_byte <= byte_sel;
      pkt.last_byte   <= last_pos;
    end
  end

endmodule

// ===== design/drive_command_packet_encoder.sv =====
// Channel  Dir  Handshake                      Payload
// cmd      in   cmd_valid / cmd_ready          dcpe_pkg::cmd_t (velocity, radius)
// pkt      out  pkt_valid / pkt_ready          dcpe_pkg::pkt_t (frame byte, last flag)
// apb      in   psel, penable, pwrite, pready  half_wheelbase_mm at byte address 0
//
// Each command yields ten byte transfers, one per cycle while pkt_ready is high,
// so in steady state the byte serializer sets how often a new command is taken.
// The speed divider takes one command at a time: a load and then eight two-bit steps.
// Synchronous reset clears all handshake state and restores half_wheelbase_mm to 115.
// A stall on pkt backs up through a two-entry frame queue to cmd_ready.
module drive_command_packet_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcpe_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  dcpe_pkg::cmd_t                cmd,
  output logic                          pkt_valid,
  input  logic                          pkt_ready,
  output dcpe_pkg::pkt_t                pkt
);

  logic [dcpe_pkg::HALF_WB_W-1:0] half_wb;
  logic                           cfg_wr;

  logic              job_valid;
  logic              job_ready;
  dcpe_pkg::job_t    job;
  logic              dq_valid;
  logic              dq_ready;
  dcpe_pkg::frame_t  dq_frame;
  logic              qb_valid;
  logic              qb_ready;
  dcpe_pkg::frame_t  qb_frame;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == dcpe_pkg::REG_HALF_WB) ? 32'(half_wb) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_wb <= dcpe_pkg::HALF_WB_RESET;
    end else if (cfg_wr && (paddr[2] == dcpe_pkg::REG_HALF_WB)) begin
      half_wb <= pwdata[dcpe_pkg::HALF_WB_W-1:0];
    end
  end

  dcpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .half_wb   (half_wb),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  dcpe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .frm_valid (dq_valid),
    .frm_ready (dq_ready),
    .frm       (dq_frame)
  );

  dcpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (dq_valid),
    .wr_ready (dq_ready),
    .wr_data  (dq_frame),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_frame)
  );

  dcpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .frm_valid (qb_valid),
    .frm_ready (qb_ready),
    .frm       (qb_frame),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

endmodule

// ===== design/dcpe_checker.sv =====
`include "assert_macros.svh"

module dcpe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [dcpe_pkg::ADDR_W-1:0]   paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready,
  input logic                          pkt_valid,
  input logic                          pkt_ready,
  input dcpe_pkg::pkt_t                pkt
);

  logic pkt_xfer;
  logic half_sel;
  logic cfg_wr_half;

  assign pkt_xfer    = pkt_valid && pkt_ready;
  assign half_sel    = (paddr[2] == dcpe_pkg::REG_HALF_WB);
  assign cfg_wr_half = psel && penable && pwrite && pready && half_sel;

  property p_pkt_hold;
    pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt);
  endproperty

  property p_frame_start;
    pkt_xfer && pkt.last_byte |=>
      !pkt_valid || ((pkt.packet_byte == dcpe_pkg::HDR0) && !pkt.last_byte);
  endproperty

  property p_cfg_read;
    cfg_wr_half |=>
      !half_sel || (prdata == 32'($past(pwdata[dcpe_pkg::HALF_WB_W-1:0])));
  endproperty

  `ASSERT_RST(a_reset_idle, rst |=> !pkt_valid, "pkt_valid high after reset")
  `ASSERT_CLK(a_pkt_hold, p_pkt_hold, "pkt changed")
  `ASSERT_CLK(a_frame_start, p_frame_start, "bad frame start")
  `ASSERT_CLK(a_cfg_read, p_cfg_read, "bad readback")

endmodule

bind drive_command_packet_encoder dcpe_checker u_checker (.*);

// ===== dv/tb_drive_command_packet_encoder.sv =====
`timescale 1ns / 1ps

module tb_drive_command_packet_encoder;

  localparam logic [dcpe_pkg::ADDR_W-1:0] HALF_WB_ADDR =
    dcpe_pkg::ADDR_W'(4 * dcpe_pkg::REG_HALF_WB);
  localparam int FRAME_LEN = 10;
  localparam int MAX_WAIT = 7;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dcpe_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  dcpe_pkg::cmd_t cmd = '0;
  logic pkt_valid;
  logic pkt_ready = 1'b0;
  dcpe_pkg::pkt_t pkt;

  logic [dcpe_pkg::HALF_WB_W-1:0] half_wb = dcpe_pkg::HALF_WB_RESET;
  dcpe_pkg::pkt_t frame_bytes_due[$];
  int mismatch_count = 0;
  int cmds_sent = 0;
  int bytes_checked = 0;
  int frames_checked = 0;
  int cfg_writes = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int rx_hold_cycles = 0;

  drive_command_packet_encoder u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .pkt_valid(pkt_valid),
    .pkt_ready(pkt_ready),
    .pkt(pkt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb_drive_command_packet_encoder: done, errors");
    $finish;
  end

  function automatic logic [15:0] wheel_speed_of(logic signed [15:0] vel,
                                                  logic signed [15:0] rad,
                                                  logic [dcpe_pkg::HALF_WB_W-1:0] half);
    longint v;
    longint r;
    longint h;
    longint s;
    v = longint'(vel);
    r = longint'(rad);
    h = longint'(half);
    if (r >= 1) begin
      s = v * (r + h) / r;
    end else if (r <= -1) begin
      s = v * (r - h) / r;
    end else begin
      s = v;
    end
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  function automatic void queue_frame(dcpe_pkg::cmd_t c);
    logic [7:0] b [FRAME_LEN];
    logic [15:0] spd;
    logic [7:0] ck;
    spd = wheel_speed_of(c.velocity_mm_s, c.radius_mm, half_wb);
    b[0] = dcpe_pkg::HDR0;
    b[1] = dcpe_pkg::HDR1;
    b[2] = dcpe_pkg::LEN_BYTE;
    b[3] = dcpe_pkg::SUB0;
    b[4] = dcpe_pkg::SUB1;
    b[5] = spd[7:0];
    b[6] = spd[15:8];
    b[7] = c.radius_mm[7:0];
    b[8] = c.radius_mm[15:8];
    ck = 8'h00;
    for (int i = 2; i < FRAME_LEN - 1; i++) ck ^= b[i];
    b[FRAME_LEN-1] = ck;
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame_bytes_due.push_back('{packet_byte: b[i], last_byte: (i == FRAME_LEN - 1)});
    end
  endfunction

  function automatic dcpe_pkg::cmd_t random_cmd();
    dcpe_pkg::cmd_t c;
    c.velocity_mm_s = 16'($urandom);
    c.radius_mm = 16'($urandom);
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        c.radius_mm = 16'(int'($urandom_range(0, 600)) - 300);
      end
      2: begin
        c.radius_mm = '0;
      end
      default: begin
        c.radius_mm = 16'(int'($urandom_range(0, 8)) - 4);
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  // The valid line is left high on return; drain_frames lowers it.
  task automatic send_cmd(logic signed [15:0] vel, logic signed [15:0] rad);
    int gap;
    dcpe_pkg::cmd_t c;
    c.velocity_mm_s = vel;
    c.radius_mm = rad;
    gap = tx_idle_en ? int'($urandom_range(0, MAX_WAIT)) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    queue_frame(c);
    cmds_sent++;
  endtask

  task automatic drain_frames();
    cmd_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= HALF_WB_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_half_wb();
    logic [31:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[dcpe_pkg::HALF_WB_W-1:0] !== half_wb) begin
      report_mismatch("half_wheelbase_mm readback", 32'(half_wb),
                      32'(rdata[dcpe_pkg::HALF_WB_W-1:0]));
    end
  endtask

  task automatic set_half_wb(logic [dcpe_pkg::HALF_WB_W-1:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, 32'(value), rdata);
    half_wb = value;
    cfg_writes++;
    check_half_wb();
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        pkt_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_idle_en ? int'($urandom_range(0, MAX_WAIT)) : 0;
      if (stall > 0) begin
        pkt_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pkt_ready <= 1'b1;
      do @(posedge clk); while (!pkt_valid);
    end
  end

  always @(posedge clk) begin
    dcpe_pkg::pkt_t want;
    if (!rst && pkt_valid && pkt_ready) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch("unexpected byte transfer", 32'd0, 32'(pkt.packet_byte));
      end else begin
        want = frame_bytes_due.pop_front();
        if (pkt.packet_byte !== want.packet_byte) begin
          report_mismatch("packet_byte", 32'(want.packet_byte), 32'(pkt.packet_byte));
        end
        if (pkt.last_byte !== want.last_byte) begin
          report_mismatch("last_byte", 32'(want.last_byte), 32'(pkt.last_byte));
        end
        bytes_checked++;
        if (want.last_byte) frames_checked++;
      end
    end
  end

  task automatic test_reset_value();
    check_half_wb();
    send_cmd(16'sd500, 16'sd200);
    send_cmd(-16'sd500, -16'sd200);
    drain_frames();
  endtask

  task automatic test_directed();
    send_cmd(16'sd0, 16'sd0);
    send_cmd(16'sd32767, 16'sd0);
    send_cmd(-16'sd32768, 16'sd0);
    send_cmd(-16'sd1, 16'sd0);
    send_cmd(16'sd1, 16'sd1);
    send_cmd(16'sd32767, 16'sd1);
    send_cmd(-16'sd32768, 16'sd1);
    send_cmd(16'sd32767, -16'sd1);
    send_cmd(-16'sd32768, -16'sd1);
    send_cmd(16'sd1000, 16'sd32767);
    send_cmd(16'sd1000, -16'sd32768);
    send_cmd(-16'sd7, 16'sd3);
    send_cmd(16'sd7, -16'sd3);
    send_cmd(16'sh5555, 16'sh5555);
    send_cmd(16'shAAAA, 16'shAAAA);
    drain_frames();
    set_half_wb('0);
    send_cmd(16'sd12345, 16'sd17);
    send_cmd(-16'sd12345, -16'sd17);
    drain_frames();
    set_half_wb('1);
    send_cmd(16'sd20000, 16'sd1);
    send_cmd(16'sd30, -16'sd1023);
    send_cmd(-16'sd1, 16'sd500);
    send_cmd(-16'sd32768, 16'sd32767);
    drain_frames();
  endtask

  // Hold the output side long enough that the frame queue fills and the command side
  // stalls, let the sender wait for every byte to return, then repeat with random stalls.
  task automatic test_pressure();
    dcpe_pkg::cmd_t c;
    set_half_wb(dcpe_pkg::HALF_WB_RESET);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_cycles = 160;
    repeat (8) begin
      c = random_cmd();
      send_cmd(c.velocity_mm_s, c.radius_mm);
    end
    drain_frames();
    rx_idle_en = 1'b1;
    repeat (4) begin
      c = random_cmd();
      send_cmd(c.velocity_mm_s, c.radius_mm);
    end
    drain_frames();
  endtask

  task automatic test_random();
    dcpe_pkg::cmd_t c;
    logic [dcpe_pkg::HALF_WB_W-1:0] settings [5];
    settings[0] = '0;
    settings[1] = '1;
    settings[2] = dcpe_pkg::HALF_WB_W'($urandom);
    settings[3] = dcpe_pkg::HALF_WB_W'(1);
    settings[4] = dcpe_pkg::HALF_WB_W'($urandom);
    for (int phase = 0; phase < 5; phase++) begin
      set_half_wb(settings[phase]);
      tx_idle_en = (phase % 2) == 1;
      rx_idle_en = (phase % 3) != 0;
      repeat (19) begin
        c = random_cmd();
        send_cmd(c.velocity_mm_s, c.radius_mm);
      end
      drain_frames();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_directed();
    test_pressure();
    test_random();
    drain_frames();
    if (frame_bytes_due.size() != 0) begin
      report_mismatch("bytes never delivered", 32'd0, 32'(frame_bytes_due.size()));
    end
    $display("Sent %0d drive commands over %0d half-wheelbase settings.",
             cmds_sent, cfg_writes + 1);
    $display("Checked %0d frames (%0d bytes), including a long output stall.",
             frames_checked, bytes_checked);
    if (mismatch_count == 0) begin
      $display("tb_drive_command_packet_encoder: done, clean");
    end else begin
      $display("tb_drive_command_packet_encoder: done, errors");
    end
    $finish;
  end

endmodule
